### rtl/pqhs_pkg.sv
// Shared sizes, codes and types for the play queue with history stack.
// No dependencies; the top level imports this package.
`timescale 1ns / 1ps
`default_nettype none
package pqhs_pkg;

  localparam int QUEUE_DEPTH   = 128;
  localparam int HISTORY_DEPTH = 128;
  localparam int ITEM_WIDTH    = 32;

  localparam int ITEM_PORT_W  = 32;
  localparam int COUNT_PORT_W = 8;
  localparam int STORE_W      = (ITEM_WIDTH < ITEM_PORT_W) ? ITEM_WIDTH : ITEM_PORT_W;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_NEXT = 2'd1;
  localparam logic [1:0] KIND_PREV = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_QFULL      = 3'd1,
    ST_QEMPTY     = 3'd2,
    ST_HEMPTY     = 3'd3,
    ST_HFULL      = 3'd4,
    ST_QFULL_PREV = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage
`default_nettype wire

### rtl/pqhs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pqhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/play_queue_with_history_stack.sv
// Top level of the play queue with history stack: control, counters and outputs.
// Depends on pqhs_pkg and on two pqhs_ram instances for the queue and the history.
//
//   Channel  Ports                                         Direction
//   in       in_valid, in_stall, in_kind, in_item          command in
//   out      out_valid, out_stall, out_status,             result out
//            out_played_item, out_played_valid,
//            out_queue_count, out_history_count
//
// Each transaction is accepted in S_IDLE while both RAMs are read at their addresses;
// S_EXEC uses the registered read data, writes back and loads the result register,
// and waits there while a held result is stalled by out_stall.
// A new transaction is taken while the previous result waits in its register.
// Reset empties the queue and the history at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module play_queue_with_history_stack (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_kind,
  input  wire logic [pqhs_pkg::ITEM_PORT_W-1:0]    in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [2:0]                               out_status,
  output logic [pqhs_pkg::ITEM_PORT_W-1:0]         out_played_item,
  output logic                                     out_played_valid,
  output logic [pqhs_pkg::COUNT_PORT_W-1:0]        out_queue_count,
  output logic [pqhs_pkg::COUNT_PORT_W-1:0]        out_history_count
);
  import pqhs_pkg::*;

  state_t              state_r, state_nxt;
  logic [1:0]          kind_r;
  logic [STORE_W-1:0]  item_r;
  logic [QAW-1:0]      head_r, head_nxt;
  logic [QAW-1:0]      tail_r, tail_nxt;
  logic [QCW-1:0]      qfill_r, qfill_nxt;
  logic [HCW-1:0]      hfill_r, hfill_nxt;
  logic [STORE_W-1:0]  top_r, top_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [STORE_W-1:0]  played_r, played_nxt;
  logic                pvalid_r, pvalid_nxt;

  logic                q_we;
  logic [QAW-1:0]      q_waddr;
  logic [STORE_W-1:0]  q_wdata;
  logic [STORE_W-1:0]  q_rdata;
  logic                h_we;
  logic [HAW-1:0]      h_waddr;
  logic [STORE_W-1:0]  h_wdata;
  logic [HCW-1:0]      h_below_top;
  logic [STORE_W-1:0]  h_rdata;

  logic                accept;
  logic                fire;
  logic                q_full, q_empty, h_full, h_empty;
  logic [QAW-1:0]      head_inc, head_dec, tail_inc;

  logic [STORE_W+ITEM_PORT_W-1:0]  played_ext;
  logic [QCW+COUNT_PORT_W-1:0]     qcount_ext;
  logic [HCW+COUNT_PORT_W-1:0]     hcount_ext;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign q_full  = (qfill_r == QCW'(QUEUE_DEPTH));
  assign q_empty = (qfill_r == '0);
  assign h_full  = (hfill_r == HCW'(HISTORY_DEPTH));
  assign h_empty = (hfill_r == '0);

  assign head_inc = (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? QAW'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  assign h_below_top = hfill_r - HCW'(2);

  pqhs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  pqhs_ram #(
    .WIDTH (STORE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_below_top[HAW-1:0]),
    .rdata (h_rdata)
  );

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    qfill_nxt  = qfill_r;
    hfill_nxt  = hfill_r;
    top_nxt    = top_r;
    status_nxt = ST_OK;
    played_nxt = '0;
    pvalid_nxt = 1'b0;
    q_we       = 1'b0;
    q_waddr    = tail_r;
    q_wdata    = item_r;
    h_we       = 1'b0;
    h_waddr    = hfill_r[HAW-1:0];
    h_wdata    = q_rdata;

    case (kind_r)
      KIND_ADD: begin
        if (q_full) begin
          status_nxt = ST_QFULL;
        end else begin
          q_we      = fire;
          tail_nxt  = tail_inc;
          qfill_nxt = qfill_r + 1'b1;
        end
      end
      KIND_NEXT: begin
        if (q_empty) begin
          status_nxt = ST_QEMPTY;
        end else begin
          played_nxt = q_rdata;
          pvalid_nxt = 1'b1;
          head_nxt   = head_inc;
          qfill_nxt  = qfill_r - 1'b1;
          if (h_full) begin
            status_nxt = ST_HFULL;
          end else begin
            h_we      = fire;
            hfill_nxt = hfill_r + 1'b1;
            top_nxt   = q_rdata;
          end
        end
      end
      KIND_PREV: begin
        if (h_empty) begin
          status_nxt = ST_HEMPTY;
        end else if (q_full) begin
          status_nxt = ST_QFULL_PREV;
        end else begin
          head_nxt  = head_dec;
          q_we      = fire;
          q_waddr   = head_dec;
          q_wdata   = top_r;
          qfill_nxt = qfill_r + 1'b1;
          hfill_nxt = hfill_r - 1'b1;
          if (hfill_r != HCW'(1)) begin
            played_nxt = h_rdata;
            pvalid_nxt = 1'b1;
            top_nxt    = h_rdata;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      qfill_r     <= '0;
      hfill_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        qfill_r <= qfill_nxt;
        hfill_r <= hfill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      item_r <= in_item[STORE_W-1:0];
    end
    if (fire) begin
      top_r    <= top_nxt;
      status_r <= status_nxt;
      played_r <= played_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  assign played_ext = (STORE_W + ITEM_PORT_W)'(played_r);
  assign qcount_ext = (QCW + COUNT_PORT_W)'(qfill_r);
  assign hcount_ext = (HCW + COUNT_PORT_W)'(hfill_r);

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_played_item   = played_ext[ITEM_PORT_W-1:0];
  assign out_played_valid  = pvalid_r;
  assign out_queue_count   = qcount_ext[COUNT_PORT_W-1:0];
  assign out_history_count = hcount_ext[COUNT_PORT_W-1:0];

endmodule
`default_nettype wire
